// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the rtl; compiled out under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent in a cycle implies consequent in the same cycle
`define GHA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent in a cycle implies consequent in the next cycle
`define GHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define GHA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/gha_pkg.sv =====
// ---------------------------------------------------------------------------
// gha_pkg
// Shared widths, request and status codes, and controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

  localparam int CAPACITY_DEF     = 1024;
  localparam int VERSION_BITS_DEF = 32;

  localparam int OPCODE_W     = 2;
  localparam int SLOT_ID_W    = 10;
  localparam int HANDLE_ID_W  = 10;
  localparam int HANDLE_VER_W = 32;
  localparam int STATUS_W     = 3;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_ALLOC    = 2'd0;
  localparam opcode_t OP_ALLOC_AT = 2'd1;
  localparam opcode_t OP_FREE     = 2'd2;
  localparam opcode_t OP_FREE_ALL = 2'd3;

  localparam status_t STS_OK       = 3'd0;
  localparam status_t STS_SUBST    = 3'd1;
  localparam status_t STS_BAD_FREE = 3'd2;
  localparam status_t STS_FULL     = 3'd3;
  localparam status_t STS_RANGE    = 3'd4;

  // table read address select
  typedef logic [1:0] rsel_t;
  localparam rsel_t RS_IN    = 2'd0;
  localparam rsel_t RS_SID   = 2'd1;
  localparam rsel_t RS_QDATA = 2'd2;
  localparam rsel_t RS_CAND  = 2'd3;

  // table write address/data select
  typedef logic [2:0] wsel_t;
  localparam wsel_t WS_FREE    = 3'd0;
  localparam wsel_t WS_BUMP    = 3'd1;
  localparam wsel_t WS_SID_NEW = 3'd2;
  localparam wsel_t WS_TS_GAP  = 3'd3;
  localparam wsel_t WS_TS_NEW  = 3'd4;
  localparam wsel_t WS_CAND    = 3'd5;

  // result id select
  typedef logic [1:0] idsel_t;
  localparam idsel_t IS_SID  = 2'd0;
  localparam idsel_t IS_CAND = 2'd1;
  localparam idsel_t IS_TS   = 2'd2;

  // result version select
  typedef logic [1:0] versel_t;
  localparam versel_t VS_ZERO = 2'd0;
  localparam versel_t VS_INC  = 2'd1;
  localparam versel_t VS_GEN  = 2'd2;

  typedef struct packed {
    logic    latch_in;
    rsel_t   tbl_rsel;
    logic    tbl_we;
    wsel_t   tbl_wsel;
    logic    push;
    logic    push_ts;
    logic    pop;
    logic    ts_inc;
    logic    ts_set_sid;
    logic    clr_all;
    logic    out_load;
    idsel_t  out_idsel;
    versel_t out_versel;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    sid_ge_cap;
    logic    sid_ge_ts;
    logic    ts_lt_sid;
    logic    used;
    logic    count_nz;
    logic    ts_lt_cap;
    logic    cand_ok;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/generational_handle_allocator_top.sv =====
// ---------------------------------------------------------------------------
// generational_handle_allocator_top
// Generational handle allocator with a recycle queue of freed ids.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

// One request is handled at a time and each gives exactly one result
// transaction, held in an output register so the next request can be taken
// while a result waits. Free, free all, allocate-at on a free or out-of-range
// id, and allocation that extends the table are accepted, then completed
// with any table read-modify-write they need. An allocation served from the
// recycle queue pops the head id and reads its table entry, then claims it;
// each stale queue entry skipped adds another pop and table read. Allocate-at
// past the table end writes each skipped id and queues it when there is room,
// one per cycle, then claims the requested id. The id table ({used, version})
// and the queue sit in RAMs with registered reads; no clearing pass is needed after reset.
module generational_handle_allocator_top #(
  parameter int CAPACITY     = gha_pkg::CAPACITY_DEF,
  parameter int VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [gha_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [gha_pkg::SLOT_ID_W-1:0]    in_slot_id,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [gha_pkg::HANDLE_ID_W-1:0]  out_handle_id,
  output logic      [gha_pkg::HANDLE_VER_W-1:0] out_handle_version,
  output logic      [gha_pkg::STATUS_W-1:0]     out_status
);
  import gha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  gha_dp #(
    .CAPACITY     (CAPACITY),
    .VERSION_BITS (VERSION_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_slot_id         (in_slot_id),
    .out_ready          (out_ready),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_handle_id      (out_handle_id),
    .out_handle_version (out_handle_version),
    .out_status         (out_status)
  );

  // a result never overwrites one still waiting
  `GHA_ASSERT_SAME(a_load_free, clk, rst_n, cmd.out_load, sts.out_free)
  // no pop from an empty queue
  `GHA_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd.pop, sts.count_nz)
  // one request in flight at a time
  `GHA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// ===== sv/gha_ram.sv =====
// ---------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/gha_dp.sv =====
// ---------------------------------------------------------------------------
// gha_dp
// Datapath: id table and recycle queue memories, queue pointers, table size,
// request latch and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gha_dp #(
  parameter int CAPACITY     = gha_pkg::CAPACITY_DEF,
  parameter int VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [gha_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [gha_pkg::SLOT_ID_W-1:0]    in_slot_id,
  input  wire logic                             out_ready,
  input  wire gha_pkg::cmd_t                    cmd,
  output gha_pkg::sts_t                         sts,
  output logic                                  out_valid,
  output logic      [gha_pkg::HANDLE_ID_W-1:0]  out_handle_id,
  output logic      [gha_pkg::HANDLE_VER_W-1:0] out_handle_version,
  output logic      [gha_pkg::STATUS_W-1:0]     out_status
);
  import gha_pkg::*;

  localparam int IDW = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int TW  = VERSION_BITS + 1;

  // request latch and queue/table bookkeeping
  opcode_t                op_r,    op_nxt;
  logic [SLOT_ID_W-1:0]   sid_r,   sid_nxt;
  logic [IDW-1:0]         head_r,  head_nxt;
  logic [IDW-1:0]         tail_r,  tail_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          ts_r,    ts_nxt;
  logic [IDW-1:0]         cand_r,  cand_nxt;

  logic                    out_valid_r,   out_valid_nxt;
  logic [HANDLE_ID_W-1:0]  out_id_r,      out_id_nxt;
  logic [HANDLE_VER_W-1:0] out_ver_r,     out_ver_nxt;
  status_t                 out_status_r,  out_status_nxt;

  logic [IDW-1:0]          sid_idx;
  logic [IDW-1:0]          ts_idx;
  logic [IDW-1:0]          q_rd_data;
  logic                    q_we;
  logic [IDW-1:0]          q_wr_data;
  logic                    q_full;
  logic [IDW-1:0]          tbl_raddr;
  logic [IDW-1:0]          tbl_waddr;
  logic [TW-1:0]           tbl_wdata;
  logic [TW-1:0]           tbl_rd_data;
  logic [VERSION_BITS-1:0] rgen;
  logic [VERSION_BITS-1:0] gen_inc;
  logic                    out_free;

  assign sid_idx = IDW'(sid_r);
  assign ts_idx  = IDW'(ts_r);
  assign rgen    = tbl_rd_data[VERSION_BITS-1:0];
  assign gen_inc = rgen + VERSION_BITS'(1);
  assign q_full  = (count_r == CW'(CAPACITY));

  // table read address
  always_comb begin
    unique case (cmd.tbl_rsel)
      RS_IN:    tbl_raddr = IDW'(in_slot_id);
      RS_SID:   tbl_raddr = sid_idx;
      RS_QDATA: tbl_raddr = q_rd_data;
      RS_CAND:  tbl_raddr = cand_r;
    endcase
  end

  // table write: {used, generation}
  always_comb begin
    unique case (cmd.tbl_wsel)
      WS_FREE: begin
        tbl_waddr = sid_idx;
        tbl_wdata = {1'b0, gen_inc};
      end
      WS_BUMP: begin
        tbl_waddr = sid_idx;
        tbl_wdata = {1'b1, gen_inc};
      end
      WS_SID_NEW: begin
        tbl_waddr = sid_idx;
        tbl_wdata = {1'b1, {VERSION_BITS{1'b0}}};
      end
      WS_TS_GAP: begin
        tbl_waddr = ts_idx;
        tbl_wdata = '0;
      end
      WS_TS_NEW: begin
        tbl_waddr = ts_idx;
        tbl_wdata = {1'b1, {VERSION_BITS{1'b0}}};
      end
      WS_CAND: begin
        tbl_waddr = cand_r;
        tbl_wdata = {1'b1, rgen};
      end
      default: begin
        tbl_waddr = sid_idx;
        tbl_wdata = '0;
      end
    endcase
  end

  // pushes into a full queue are dropped
  assign q_we      = cmd.push && !q_full;
  assign q_wr_data = cmd.push_ts ? ts_idx : sid_idx;

  gha_ram #(
    .WIDTH (TW),
    .DEPTH (CAPACITY)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (cmd.tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rd_data)
  );

  // queue is always read at the head
  gha_ram #(
    .WIDTH (IDW),
    .DEPTH (CAPACITY)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (tail_r),
    .wr_data (q_wr_data),
    .rd_addr (head_r),
    .rd_data (q_rd_data)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    op_nxt    = op_r;
    sid_nxt   = sid_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ts_nxt    = ts_r;
    cand_nxt  = cand_r;

    if (cmd.latch_in) begin
      op_nxt  = in_opcode;
      sid_nxt = in_slot_id;
    end

    if (q_we) begin
      tail_nxt  = (tail_r == IDW'(CAPACITY - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end

    if (cmd.pop) begin
      head_nxt  = (head_r == IDW'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
      cand_nxt  = q_rd_data;
    end

    if (cmd.ts_inc) begin
      ts_nxt = ts_r + 1'b1;
    end else if (cmd.ts_set_sid) begin
      ts_nxt = CW'(sid_r) + CW'(1);
    end

    if (cmd.clr_all) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      ts_nxt    = '0;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_id_nxt     = out_id_r;
    out_ver_nxt    = out_ver_r;
    out_status_nxt = out_status_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.out_status;
      unique case (cmd.out_idsel)
        IS_SID:  out_id_nxt = HANDLE_ID_W'(sid_r);
        IS_CAND: out_id_nxt = HANDLE_ID_W'(cand_r);
        IS_TS:   out_id_nxt = HANDLE_ID_W'(ts_r);
        default: out_id_nxt = HANDLE_ID_W'(sid_r);
      endcase
      unique case (cmd.out_versel)
        VS_ZERO: out_ver_nxt = '0;
        VS_INC:  out_ver_nxt = HANDLE_VER_W'(gen_inc);
        VS_GEN:  out_ver_nxt = HANDLE_VER_W'(rgen);
        default: out_ver_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ts_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ts_r        <= ts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sid_r        <= sid_nxt;
    cand_r       <= cand_nxt;
    out_id_r     <= out_id_nxt;
    out_ver_r    <= out_ver_nxt;
    out_status_r <= out_status_nxt;
  end

  assign sts.op         = op_r;
  assign sts.sid_ge_cap = (32'(sid_r) >= CAPACITY);
  assign sts.sid_ge_ts  = (32'(sid_r) >= 32'(ts_r));
  assign sts.ts_lt_sid  = (32'(ts_r) < 32'(sid_r));
  assign sts.used       = tbl_rd_data[VERSION_BITS];
  assign sts.count_nz   = (count_r != '0);
  assign sts.ts_lt_cap  = (ts_r != CW'(CAPACITY));
  assign sts.cand_ok    = (32'(cand_r) < 32'(ts_r)) && !tbl_rd_data[VERSION_BITS];
  assign sts.out_free   = out_free;

  assign out_valid          = out_valid_r;
  assign out_handle_id      = out_id_r;
  assign out_handle_version = out_ver_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

// ===== sv/gha_ctrl.sv =====
// ---------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: decode, gap walk, queue pop and stale entry skip.
// ---------------------------------------------------------------------------
`default_nettype none

module gha_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire gha_pkg::sts_t sts,
  output gha_pkg::cmd_t      cmd,
  output logic               in_ready
);
  import gha_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_GAP  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_CAND = 3'd4;

  logic [2:0] state_r, state_nxt;
  cmd_t       pop_cmd;
  logic [2:0] pop_nxt;
  status_t    alloc_ok;

  // a busy allocate-at that falls back reports a substitution
  assign alloc_ok = (sts.op == OP_ALLOC_AT) ? STS_SUBST : STS_OK;

  // plain allocation step: pop a queued id, else extend, else full
  always_comb begin
    pop_cmd          = '0;
    pop_cmd.tbl_rsel = RS_SID;
    pop_nxt          = state_r;
    if (sts.count_nz) begin
      pop_cmd.pop      = 1'b1;
      pop_cmd.tbl_rsel = RS_QDATA;
      pop_nxt          = S_CAND;
    end else if (sts.out_free) begin
      pop_cmd.out_load = 1'b1;
      pop_nxt          = S_IDLE;
      if (sts.ts_lt_cap) begin
        pop_cmd.tbl_we     = 1'b1;
        pop_cmd.tbl_wsel   = WS_TS_NEW;
        pop_cmd.ts_inc     = 1'b1;
        pop_cmd.out_idsel  = IS_TS;
        pop_cmd.out_versel = VS_ZERO;
        pop_cmd.out_status = alloc_ok;
      end else begin
        pop_cmd.out_idsel  = IS_SID;
        pop_cmd.out_versel = VS_ZERO;
        pop_cmd.out_status = STS_FULL;
      end
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.tbl_rsel = RS_IN;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.tbl_rsel = RS_SID;
        unique case (sts.op)
          OP_FREE_ALL: begin
            if (sts.out_free) begin
              cmd.clr_all    = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_idsel  = IS_SID;
              cmd.out_versel = VS_ZERO;
              cmd.out_status = STS_OK;
              state_nxt      = S_IDLE;
            end
          end
          OP_FREE: begin
            if (sts.out_free) begin
              cmd.out_load  = 1'b1;
              cmd.out_idsel = IS_SID;
              state_nxt     = S_IDLE;
              if (!sts.sid_ge_ts && sts.used) begin
                cmd.tbl_we     = 1'b1;
                cmd.tbl_wsel   = WS_FREE;
                cmd.push       = 1'b1;
                cmd.out_versel = VS_INC;
                cmd.out_status = STS_OK;
              end else begin
                cmd.out_versel = VS_ZERO;
                cmd.out_status = STS_BAD_FREE;
              end
            end
          end
          OP_ALLOC_AT: begin
            priority if (sts.sid_ge_cap) begin
              if (sts.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_idsel  = IS_SID;
                cmd.out_versel = VS_ZERO;
                cmd.out_status = STS_RANGE;
                state_nxt      = S_IDLE;
              end
            end else if (sts.sid_ge_ts) begin
              state_nxt = S_GAP;
            end else if (!sts.used) begin
              if (sts.out_free) begin
                cmd.tbl_we     = 1'b1;
                cmd.tbl_wsel   = WS_BUMP;
                cmd.out_load   = 1'b1;
                cmd.out_idsel  = IS_SID;
                cmd.out_versel = VS_INC;
                cmd.out_status = STS_OK;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd       = pop_cmd;
              state_nxt = pop_nxt;
            end
          end
          OP_ALLOC: begin
            cmd       = pop_cmd;
            state_nxt = pop_nxt;
          end
        endcase
      end
      S_GAP: begin
        // one skipped id per cycle, then claim the requested one
        if (sts.ts_lt_sid) begin
          cmd.tbl_we   = 1'b1;
          cmd.tbl_wsel = WS_TS_GAP;
          cmd.push     = 1'b1;
          cmd.push_ts  = 1'b1;
          cmd.ts_inc   = 1'b1;
        end else if (sts.out_free) begin
          cmd.tbl_we     = 1'b1;
          cmd.tbl_wsel   = WS_SID_NEW;
          cmd.ts_set_sid = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_idsel  = IS_SID;
          cmd.out_versel = VS_ZERO;
          cmd.out_status = STS_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_CAND: begin
        cmd.tbl_rsel = RS_CAND;
        if (sts.cand_ok) begin
          if (sts.out_free) begin
            cmd.tbl_we     = 1'b1;
            cmd.tbl_wsel   = WS_CAND;
            cmd.out_load   = 1'b1;
            cmd.out_idsel  = IS_CAND;
            cmd.out_versel = VS_GEN;
            cmd.out_status = alloc_ok;
            state_nxt      = S_IDLE;
          end
        end else begin
          // stale entry, pop the next one
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd       = pop_cmd;
        state_nxt = pop_nxt;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the generational handle allocator against an in-bench model of its
// id table, versions and recycle queue, with random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import gha_pkg::*;

  localparam int NUM_IDS     = 1024;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [HANDLE_ID_W-1:0]  id;
    logic [HANDLE_VER_W-1:0] ver;
    status_t                 st;
  } handle_res_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OPCODE_W-1:0]     in_opcode = OP_ALLOC;
  logic [SLOT_ID_W-1:0]    in_slot_id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [HANDLE_ID_W-1:0]  out_handle_id;
  logic [HANDLE_VER_W-1:0] out_handle_version;
  logic [STATUS_W-1:0]     out_status;

  // model of the allocator state
  bit                      slot_used [NUM_IDS];
  logic [HANDLE_VER_W-1:0] slot_gen [NUM_IDS];
  logic [SLOT_ID_W-1:0]    recycle_q [NUM_IDS];
  int                      rq_head = 0;
  int                      rq_tail = 0;
  int                      rq_count = 0;
  int                      tbl_size = 0;

  handle_res_t pending_handles[$];
  handle_res_t want;

  bit quiet = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycle_count = 0;
  int status_seen [8];

  generational_handle_allocator_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_slot_id         (in_slot_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_handle_id      (out_handle_id),
    .out_handle_version (out_handle_version),
    .out_status         (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_handles.size());
      $display("generational_handle_allocator_top test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // allocator model
  // ------------------------------------------------------------------------
  function automatic void recycle_push(input logic [SLOT_ID_W-1:0] id);
    if (rq_count >= NUM_IDS) begin
      return;
    end
    recycle_q[rq_tail] = id;
    rq_tail = (rq_tail + 1 >= NUM_IDS) ? 0 : rq_tail + 1;
    rq_count++;
  endfunction

  function automatic logic [SLOT_ID_W-1:0] recycle_pop();
    logic [SLOT_ID_W-1:0] id;
    id = recycle_q[rq_head];
    rq_head = (rq_head + 1 >= NUM_IDS) ? 0 : rq_head + 1;
    rq_count--;
    return id;
  endfunction

  function automatic bit take_free_id(output logic [HANDLE_ID_W-1:0] id,
                                      output logic [HANDLE_VER_W-1:0] ver);
    logic [SLOT_ID_W-1:0] c;
    id = '0;
    ver = '0;
    while (rq_count > 0) begin
      c = recycle_pop();
      // stale entries (already in use again) are dropped
      if (int'(c) < tbl_size && !slot_used[c]) begin
        slot_used[c] = 1'b1;
        id = c;
        ver = slot_gen[c];
        return 1'b1;
      end
    end
    if (tbl_size < NUM_IDS) begin
      slot_used[tbl_size] = 1'b1;
      slot_gen[tbl_size] = '0;
      id = tbl_size[HANDLE_ID_W-1:0];
      tbl_size++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic handle_res_t predict_handle(input opcode_t op,
                                                 input logic [SLOT_ID_W-1:0] sid);
    handle_res_t res;
    logic [HANDLE_ID_W-1:0] id;
    logic [HANDLE_VER_W-1:0] ver;
    int s;
    s = int'(sid);
    res.id = sid;
    res.ver = '0;
    res.st = STS_OK;
    case (op)
      OP_ALLOC: begin
        if (take_free_id(id, ver)) begin
          res.id = id;
          res.ver = ver;
        end else begin
          res.st = STS_FULL;
        end
      end
      OP_ALLOC_AT: begin
        if (s >= NUM_IDS) begin
          res.st = STS_RANGE;
        end else if (s >= tbl_size) begin
          for (int g = tbl_size; g < s; g++) begin
            slot_used[g] = 1'b0;
            slot_gen[g] = '0;
            recycle_push(g[SLOT_ID_W-1:0]);
          end
          slot_used[s] = 1'b1;
          slot_gen[s] = '0;
          tbl_size = s + 1;
        end else if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          slot_gen[s] = slot_gen[s] + 1'b1;
          res.ver = slot_gen[s];
        end else if (take_free_id(id, ver)) begin
          res.id = id;
          res.ver = ver;
          res.st = STS_SUBST;
        end else begin
          res.st = STS_FULL;
        end
      end
      OP_FREE: begin
        if (s < tbl_size && slot_used[s]) begin
          slot_used[s] = 1'b0;
          recycle_push(sid);
          slot_gen[s] = slot_gen[s] + 1'b1;
          res.ver = slot_gen[s];
        end else begin
          res.st = STS_BAD_FREE;
        end
      end
      default: begin
        tbl_size = 0;
        rq_head = 0;
        rq_tail = 0;
        rq_count = 0;
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // drivers and result checker
  // ------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_handles.size() == 0) begin
        $display("%0t: unexpected result id %0d version %0d status %0d", $time,
                 out_handle_id, out_handle_version, out_status);
        errors++;
      end else begin
        want = pending_handles.pop_front();
        n_checked++;
        status_seen[out_status]++;
        if (out_handle_id !== want.id) begin
          $display("%0t: handle_id mismatch expected %0d actual %0d", $time,
                   want.id, out_handle_id);
          errors++;
        end
        if (out_handle_version !== want.ver) begin
          $display("%0t: handle_version mismatch expected %0d actual %0d", $time,
                   want.ver, out_handle_version);
          errors++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want.st, out_status);
          errors++;
        end
      end
    end
  end

  // every call starts at a falling edge, so valid is never lowered and raised in one step
  task automatic send_request(input opcode_t op, input logic [SLOT_ID_W-1:0] sid);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_slot_id <= sid;
    do @(posedge clk); while (!in_ready);
    pending_handles.insert(pending_handles.size(), predict_handle(op, sid));
    n_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_handles.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [SLOT_ID_W-1:0] rand_id();
    return SLOT_ID_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [SLOT_ID_W-1:0] pick_used_id();
    logic [SLOT_ID_W-1:0] id;
    id = '0;
    if (tbl_size == 0) begin
      return id;
    end
    for (int k = 0; k < 8; k++) begin
      id = SLOT_ID_W'($urandom_range(0, tbl_size - 1));
      if (slot_used[id]) begin
        return id;
      end
    end
    return id;
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_alloc_free();
    send_request(OP_ALLOC, 10'h3FF);
    send_request(OP_ALLOC, 10'h000);
    send_request(OP_FREE, 10'd0);
    send_request(OP_FREE, 10'd0);     // not in use
    send_request(OP_FREE, 10'd9);     // past the table end
    send_request(OP_ALLOC, rand_id());
    send_request(OP_FREE_ALL, 10'h3FF);
    send_request(OP_ALLOC, 10'h000);
  endtask

  task automatic test_alloc_at();
    send_request(OP_ALLOC_AT, 10'd4);   // grows, gap ids queued
    send_request(OP_ALLOC_AT, 10'd2);   // free id inside table, version bump
    send_request(OP_ALLOC_AT, 10'd4);   // busy, substituted
    send_request(OP_ALLOC, 10'd0);      // skips stale queued id
    send_request(OP_ALLOC, 10'd0);
    send_request(OP_FREE, 10'd3);
    send_request(OP_FREE, 10'd5);
    send_request(OP_ALLOC_AT, 10'd0);
    send_request(OP_ALLOC_AT, 10'h3FF); // largest id, long gap walk
    send_request(OP_FREE, 10'h3FF);
    send_request(OP_FREE, 10'h200);
    send_request(OP_FREE_ALL, 10'h2AA);
  endtask

  task automatic test_random_traffic(input int n_items);
    int r;
    int r2;
    logic [SLOT_ID_W-1:0] sid;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      r2 = $urandom_range(0, 99);
      if (tbl_size > 256 || r >= 97) begin
        send_request(OP_FREE_ALL, rand_id());
      end else if (r < 35) begin
        send_request(OP_ALLOC, rand_id());
      end else if (r < 55) begin
        if (r2 < 3) begin
          sid = rand_id();
        end else if (r2 < 70 && tbl_size > 0) begin
          sid = SLOT_ID_W'($urandom_range(0, tbl_size - 1));
        end else begin
          r2 = tbl_size + $urandom_range(0, 6);
          sid = (r2 > 1023) ? 10'h3FF : r2[SLOT_ID_W-1:0];
        end
        send_request(OP_ALLOC_AT, sid);
      end else if (r < 85) begin
        send_request(OP_FREE, pick_used_id());
      end else begin
        send_request(OP_FREE, rand_id());
      end
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls while the sender keeps offering
    hold_left = 400;
    test_random_traffic(40);
    wait_all_results();
    test_random_traffic(30);
    wait_all_results();
  endtask

  task automatic test_capacity_limits();
    send_request(OP_FREE_ALL, rand_id());
    send_request(OP_ALLOC_AT, 10'h3FF);
    send_request(OP_FREE, 10'h3FF);     // recycle queue now full
    send_request(OP_ALLOC_AT, 10'h3FF); // leaves a stale queued copy
    send_request(OP_FREE, 10'h3FF);     // push dropped, queue full
    send_request(OP_ALLOC_AT, 10'h3FF);
    for (int i = 0; i < 16; i++) begin
      send_request(OP_ALLOC, rand_id());
    end
    send_request(OP_ALLOC_AT, 10'd5);   // busy, substituted by a queued id
    send_request(OP_FREE, 10'd700);     // queued gap id, never handed out
    send_request(OP_FREE_ALL, rand_id());
  endtask

  initial begin
    for (int i = 0; i < NUM_IDS; i++) begin
      slot_used[i] = 1'b0;
      slot_gen[i] = '0;
      recycle_q[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      status_seen[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_alloc_free();
    test_alloc_at();
    test_random_traffic(250);
    quiet = 1'b1;
    test_random_traffic(150);
    quiet = 1'b0;
    test_backpressure();
    test_random_traffic(100);
    test_capacity_limits();

    wait_all_results();
    repeat (50) @(negedge clk);

    $display("sent %0d requests, checked %0d results, %0d mismatches", n_sent, n_checked,
             errors);
    $display("statuses seen: ok %0d, substituted %0d, bad free %0d, table full %0d",
             status_seen[STS_OK], status_seen[STS_SUBST], status_seen[STS_BAD_FREE],
             status_seen[STS_FULL]);
    if (errors == 0 && pending_handles.size() == 0) begin
      $display("generational_handle_allocator_top test passed");
    end else begin
      $display("generational_handle_allocator_top test failed");
    end
    $finish;
  end

endmodule
